// File: hdl/bctrr_pkg.sv
// Shared constants, types and control structures for the block cache tag controller.
package bctrr_pkg;

    localparam int ENTRIES   = 16;
    localparam int ADDR_BITS = 32;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int CFG_W     = 5;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = CFG_W'(ENTRIES);
    localparam logic             REG_ENTRIES   = 1'b0;

    typedef enum logic [1:0] {
        ACT_LOOKUP     = 2'd0,
        ACT_FETCH      = 2'd1,
        ACT_MARK_DIRTY = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_REDUCE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic start;
        logic reduce;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic is_fetch;
        logic ptr_over;
        logic scan_done;
    } t_dp_sts;

endpackage

// File: hdl/bctrr_if.sv
// Request and response channel interfaces of the block cache tag controller.
interface bctrr_req_if;
    import bctrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [1:0]           action;
    logic [ADDR_BITS-1:0] block_addr;

    modport source (output valid, action, block_addr, input ready);
    modport sink (input valid, action, block_addr, output ready);
endinterface

interface bctrr_rsp_if;
    import bctrr_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 found;
    logic [IDX_W-1:0]     entry_index;
    logic                 writeback;
    logic [ADDR_BITS-1:0] writeback_addr;

    modport source (output valid, found, entry_index, writeback, writeback_addr, input ready);
    modport sink (input valid, found, entry_index, writeback, writeback_addr, output ready);
endinterface

// File: hdl/bctrr_cfg.sv
// APB register block holding the entries-in-use setting.
module bctrr_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bctrr_pkg::APB_AW-1:0] paddr,
    input  logic [bctrr_pkg::APB_DW-1:0] pwdata,
    output logic [bctrr_pkg::APB_DW-1:0] prdata,
    output logic                         pready,
    output logic [bctrr_pkg::CFG_W-1:0]  o_entries_in_use
);
    import bctrr_pkg::*;

    logic [CFG_W-1:0] r_entries_in_use;
    logic             sel_entries;

    assign sel_entries = (paddr[2] == REG_ENTRIES);
    assign pready      = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entries_in_use <= ENTRIES_RESET;
        end else if (psel && penable && pwrite && sel_entries) begin
            r_entries_in_use <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata           = sel_entries ? APB_DW'(r_entries_in_use) : '0;
    assign o_entries_in_use = r_entries_in_use;

endmodule

// File: hdl/bctrr_ctrl.sv
// Controller state machine sequencing compare, pointer reduction, victim scan and commit.
module bctrr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    input  logic                i_rsp_ready,
    output logic                o_rsp_valid,
    input  bctrr_pkg::t_dp_sts  i_sts,
    output bctrr_pkg::t_dp_cmd  o_cmd
);
    import bctrr_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_rsp_valid;
    logic   out_free;

    assign out_free = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.commit) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = i_sts.is_fetch ? S_REDUCE : S_FINISH;
            end
            S_REDUCE: begin
                if (i_sts.ptr_over) begin
                    o_cmd.reduce = 1'b1;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

// File: hdl/bctrr_dp.sv
// Datapath with tag, valid and dirty storage, match compare, victim pointer and result register.
module bctrr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bctrr_pkg::t_dp_cmd              i_cmd,
    output bctrr_pkg::t_dp_sts              o_sts,
    input  logic [bctrr_pkg::CFG_W-1:0]     i_entries_in_use,
    input  logic [1:0]                      i_action,
    input  logic [bctrr_pkg::ADDR_BITS-1:0] i_block_addr,
    output logic                            o_found,
    output logic [bctrr_pkg::IDX_W-1:0]     o_entry_index,
    output logic                            o_writeback,
    output logic [bctrr_pkg::ADDR_BITS-1:0] o_writeback_addr
);
    import bctrr_pkg::*;

    logic [ADDR_BITS-1:0] r_tag [ENTRIES];
    logic [ENTRIES-1:0]   r_valid;
    logic [ENTRIES-1:0]   r_dirty;
    logic [IDX_W-1:0]     r_victim;
    logic [1:0]           r_action;
    logic [ADDR_BITS-1:0] r_addr;
    logic [IDX_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_step;
    logic                 r_wb;
    logic [ENTRIES-1:0]   r_match;
    logic                 r_found;
    logic [IDX_W-1:0]     r_index;
    logic                 r_out_wb;
    logic [ADDR_BITS-1:0] r_out_wb_addr;

    logic [CNT_W-1:0]     active_n;
    logic [CNT_W-1:0]     ptr_inc;
    logic [IDX_W-1:0]     cand;
    logic [CNT_W-1:0]     step_inc;
    logic [ENTRIES-1:0]   n_match;
    logic                 hit_any;
    logic [IDX_W-1:0]     hit_idx;
    logic                 is_fetch;

    always_comb begin
        if (i_entries_in_use == '0) begin
            active_n = CNT_W'(1);
        end else if (CNT_W'(i_entries_in_use) > CNT_W'(ENTRIES)) begin
            active_n = CNT_W'(ENTRIES);
        end else begin
            active_n = CNT_W'(i_entries_in_use);
        end
    end

    assign is_fetch = (r_action == ACT_FETCH);
    assign ptr_inc  = CNT_W'(r_ptr) + CNT_W'(1);
    assign cand     = (ptr_inc == active_n) ? '0 : ptr_inc[IDX_W-1:0];
    assign step_inc = r_step + CNT_W'(1);

    assign o_sts.is_fetch  = is_fetch;
    assign o_sts.ptr_over  = (CNT_W'(r_ptr) >= active_n);
    assign o_sts.scan_done = !r_dirty[cand] || (step_inc == active_n);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            n_match[i] = r_valid[i] && (r_tag[i] == r_addr) && (CNT_W'(i) < active_n);
        end
    end

    always_comb begin
        hit_any = |r_match;
        hit_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_dirty  <= '0;
            r_victim <= '0;
        end else if (i_cmd.commit) begin
            if (is_fetch) begin
                r_valid[r_ptr] <= 1'b1;
                r_dirty[r_ptr] <= 1'b0;
                r_victim       <= r_ptr;
            end else if (r_action == ACT_MARK_DIRTY && hit_any) begin
                r_dirty[hit_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && is_fetch) begin
            r_tag[r_ptr] <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_addr   <= i_block_addr;
            r_ptr    <= r_victim;
            r_step   <= '0;
            r_wb     <= 1'b0;
        end
        if (i_cmd.start) begin
            r_match <= n_match;
        end
        if (i_cmd.reduce) begin
            r_ptr <= IDX_W'(CNT_W'(r_ptr) - active_n);
        end
        if (i_cmd.scan) begin
            r_ptr  <= cand;
            r_step <= step_inc;
            r_wb   <= r_dirty[cand];
        end
        if (i_cmd.commit) begin
            if (is_fetch) begin
                r_found       <= 1'b1;
                r_index       <= r_ptr;
                r_out_wb      <= r_wb;
                r_out_wb_addr <= r_wb ? r_tag[r_ptr] : '0;
            end else begin
                r_found       <= hit_any;
                r_index       <= hit_idx;
                r_out_wb      <= 1'b0;
                r_out_wb_addr <= '0;
            end
        end
    end

    assign o_found          = r_found;
    assign o_entry_index    = r_index;
    assign o_writeback      = r_out_wb;
    assign o_writeback_addr = r_out_wb_addr;

endmodule

// File: hdl/block_cache_tag_round_robin_core.sv
// Top level of the fully associative block cache tag and round-robin replacement controller.
//
//  Channel   Direction  Handshake      Contents
//  i_req     in         valid/ready    action, block_addr
//  o_rsp     out        valid/ready    found, entry_index, writeback, writeback_addr
//  APB       in/out     psel/penable   entries_in_use at byte address 0
//
// A lookup or mark-dirty transaction steps through accept, tag compare and result.
// A fetch steps through accept, tag compare, pointer reduction, victim scan (1 to
// entries in use steps) and result; the reduction subtracts the entry count while
// the pointer lies beyond it. The scan of dirty bits checks one entry per cycle.
// One transaction is in flight at a time; the result register lets the next one start
// while a result still waits. Reset clears valid and dirty bits at once; no clearing pass.
module block_cache_tag_round_robin_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    bctrr_req_if.sink                    i_req,
    bctrr_rsp_if.source                  o_rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bctrr_pkg::APB_AW-1:0] paddr,
    input  logic [bctrr_pkg::APB_DW-1:0] pwdata,
    output logic [bctrr_pkg::APB_DW-1:0] prdata,
    output logic                         pready
);
    import bctrr_pkg::*;

    logic [CFG_W-1:0] entries_in_use;
    t_dp_cmd          dp_cmd;
    t_dp_sts          dp_sts;

    bctrr_cfg u_cfg (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .o_entries_in_use (entries_in_use)
    );

    bctrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_rsp_ready (o_rsp.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bctrr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_sts            (dp_sts),
        .i_entries_in_use (entries_in_use),
        .i_action         (i_req.action),
        .i_block_addr     (i_req.block_addr),
        .o_found          (o_rsp.found),
        .o_entry_index    (o_rsp.entry_index),
        .o_writeback      (o_rsp.writeback),
        .o_writeback_addr (o_rsp.writeback_addr)
    );

endmodule
